// ===== hdl/mvst_pkg.sv =====
// mvst_pkg: shared types, constants and helpers for the mandelbulb voxel test
// holds the cordic request type, angle table, field widths and saturation
// no dependencies
package mvst_pkg;

  // field widths
  localparam int IDX_W     = 7;
  localparam int IDX_DEPTH = 1 << IDX_W;
  localparam int MAXIT_W   = 6;
  localparam int STEP_W    = 7;
  localparam int PCNT_W    = 22;
  localparam int PIDX_W    = 21;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  // arithmetic widths
  localparam int WW  = 32;          // q10.22 coordinate
  localparam int OPW = 33;          // multiplier operand
  localparam int PW  = 2 * OPW;     // multiplier product
  localparam int CW  = 36;          // cordic x/y datapath
  localparam int ZW  = 34;          // cordic angle accumulator
  localparam int CORDIC_STEPS = 24;

  localparam logic [MAXIT_W-1:0] MAXIT_RST = 6'd20;
  localparam longint ONE_Q22 = 64'sd4194304;
  localparam logic [63:0] R2_LIMIT = 64'h0000_4000_0000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic signed [CW-1:0] CORDIC_K = 36'sd2547003;
  localparam logic signed [PW-1:0] SAT_HI = 66'sh0_7FFF_FFFF;
  localparam logic signed [PW-1:0] SAT_LO = -66'sh0_8000_0000;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef logic signed [WW-1:0] coord_tab_t [IDX_DEPTH];

  // request from the sequencer to the cordic unit
  typedef struct packed {
    logic start;
    logic vec_mode;
  } cord_req_t;

  // clamp a product sum to the signed 32-bit range
  function automatic logic signed [WW-1:0] sat32(input logic signed [PW-1:0] v);
    logic signed [WW-1:0] res;
    if (v > SAT_HI) begin
      res = SAT_HI[WW-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[WW-1:0];
    end else begin
      res = v[WW-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/mandelbulb_voxel_surface_test.sv =====
// mandelbulb_voxel_surface_test: power-8 mandelbulb escape test per voxel
// with surface point marking along k; uses mvst_pkg and mvst_cordic
//
// One voxel is processed at a time; in_tready is high only while the block is
// idle, and a finished result waits in the output register so the next voxel
// can start. Every iteration runs through one shared 33x33 multiplier (nine
// products), a bit-serial square root and one shared cordic unit used four
// times. The limit register is written through the cfg channel, which is
// always ready.
module mandelbulb_voxel_surface_test #(
  parameter int GRID_SIZE = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // cfg_data: max_iterations[5:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  // in_tdata: index_i[6:0], index_j[13:7], index_k[20:14], zero pad[23:21]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // out_tdata: inside_res[0], step_count[7:1], emit_point[8],
  // point_index[29:9], out_i[36:30], out_j[43:37], out_k[50:44], zero pad[55:51]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata
);
  import mvst_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_CORD = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [3:0] M_XX  = 4'd0;
  localparam logic [3:0] M_YY  = 4'd1;
  localparam logic [3:0] M_ZZ  = 4'd2;
  localparam logic [3:0] M_Q2  = 4'd3;
  localparam logic [3:0] M_Q4  = 4'd4;
  localparam logic [3:0] M_T   = 4'd5;
  localparam logic [3:0] M_NX  = 4'd6;
  localparam logic [3:0] M_NY  = 4'd7;
  localparam logic [3:0] M_NZ  = 4'd8;

  localparam logic [1:0] C_TH  = 2'd0;
  localparam logic [1:0] C_PH  = 2'd1;
  localparam logic [1:0] C_ST  = 2'd2;
  localparam logic [1:0] C_SP  = 2'd3;

  localparam int SQW = 47;

  // coordinate of every grid index, worked out at elaboration
  function automatic coord_tab_t build_coord();
    coord_tab_t tab;
    longint     num;
    for (int n = 0; n < IDX_DEPTH; n++) begin
      num    = longint'(n) * 2 * ONE_Q22;
      tab[n] = WW'(num / GRID_SIZE - ONE_Q22);
    end
    return tab;
  endfunction

  localparam coord_tab_t COORD_TAB = build_coord();

  // control state
  logic [2:0]          state_r;
  logic [3:0]          mop_r;
  logic                mph_r;
  logic [1:0]          cop_r;
  logic                cbusy_r;
  logic [MAXIT_W-1:0]  max_it_r;
  logic                in_run_r;
  logic [PCNT_W-1:0]   pcnt_r;
  logic                out_valid_r;

  // datapath
  logic [IDX_W-1:0]    ii_r, jj_r, kk_r;
  logic signed [WW-1:0] cx_r, cy_r, cz_r;
  logic signed [WW-1:0] wx_r, wy_r, wz_r;
  logic [STEP_W-1:0]   steps_r;
  logic                inside_r;
  logic [63:0]         rxy_r;
  logic [24:0]         q_r;
  logic [26:0]         q4_r;
  logic [30:0]         r8_r;
  logic [SQW-1:0]      sq_v_r, sq_res_r, sq_bit_r;
  logic [23:0]         rho_r;
  logic [31:0]         th_r, ph_r;
  logic signed [OPW-1:0] st_r, ct_r, sp_r, cp_r, t_r;
  logic signed [PW-1:0]  prod_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic signed [OPW-1:0] mul_a, mul_b;
  logic signed [PW-1:0]  prod_sh;
  logic [63:0]           r2;
  logic [STEP_W-1:0]     steps_inc;
  logic [SQW-1:0]        sq_try;
  cord_req_t             creq;
  logic signed [CW-1:0]  c_a, c_b, c_x, c_y;
  logic [31:0]           c_ang, c_ang_out;
  logic                  c_done;
  logic                  run_eff;
  logic                  emit;
  logic                  out_load;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mop_r)
      M_XX: begin mul_a = {wx_r[WW-1], wx_r}; mul_b = {wx_r[WW-1], wx_r}; end
      M_YY: begin mul_a = {wy_r[WW-1], wy_r}; mul_b = {wy_r[WW-1], wy_r}; end
      M_ZZ: begin mul_a = {wz_r[WW-1], wz_r}; mul_b = {wz_r[WW-1], wz_r}; end
      M_Q2: begin mul_a = $signed({8'b0, q_r}); mul_b = $signed({8'b0, q_r}); end
      M_Q4: begin mul_a = $signed({6'b0, q4_r}); mul_b = $signed({6'b0, q4_r}); end
      M_T:  begin mul_a = $signed({2'b0, r8_r}); mul_b = st_r; end
      M_NX: begin mul_a = t_r; mul_b = cp_r; end
      M_NY: begin mul_a = t_r; mul_b = sp_r; end
      M_NZ: begin mul_a = $signed({2'b0, r8_r}); mul_b = ct_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // product consumers
  always_comb begin
    prod_sh   = prod_r >>> 22;
    r2        = rxy_r + prod_r[63:0];
    steps_inc = steps_r + 7'd1;
    sq_try    = sq_res_r + sq_bit_r;
  end

  // cordic operand select
  always_comb begin
    creq.start    = (state_r == S_CORD) && !cbusy_r;
    creq.vec_mode = !cop_r[1];
    c_a   = '0;
    c_b   = '0;
    c_ang = '0;
    case (cop_r)
      C_TH: begin
        c_a = CW'(wz_r);
        c_b = $signed({{(CW-24){1'b0}}, rho_r});
      end
      C_PH: begin
        c_a = CW'(wx_r);
        c_b = CW'(wy_r);
      end
      C_ST: c_ang = {th_r[28:0], 3'b000};
      C_SP: c_ang = {ph_r[28:0], 3'b000};
      default: c_ang = '0;
    endcase
  end

  mvst_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (creq),
    .a_in    (c_a),
    .b_in    (c_b),
    .ang_in  (c_ang),
    .done    (c_done),
    .ang_out (c_ang_out),
    .x_out   (c_x),
    .y_out   (c_y)
  );

  // surface run bookkeeping
  always_comb begin
    run_eff  = (kk_r == '0) ? 1'b0 : in_run_r;
    emit     = inside_r && !run_eff;
    out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);
  end

  // multiplier result register
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mop_r    <= M_XX;
      mph_r    <= 1'b0;
      cop_r    <= C_TH;
      cbusy_r  <= 1'b0;
      in_run_r <= 1'b0;
      pcnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            ii_r    <= in_tdata[6:0];
            jj_r    <= in_tdata[13:7];
            kk_r    <= in_tdata[20:14];
            cx_r    <= COORD_TAB[in_tdata[6:0]];
            cy_r    <= COORD_TAB[in_tdata[13:7]];
            cz_r    <= COORD_TAB[in_tdata[20:14]];
            wx_r    <= '0;
            wy_r    <= '0;
            wz_r    <= '0;
            steps_r <= '0;
            mop_r   <= M_XX;
            mph_r   <= 1'b0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          mph_r <= !mph_r;
          if (mph_r) begin
            case (mop_r)
              M_XX: begin
                rxy_r <= prod_r[63:0];
                mop_r <= M_YY;
              end
              M_YY: begin
                rxy_r <= r2;
                mop_r <= M_ZZ;
              end
              M_ZZ: begin
                steps_r <= steps_inc;
                if (r2 > R2_LIMIT) begin
                  inside_r <= 1'b0;
                  state_r  <= S_DONE;
                end else if (steps_inc > {1'b0, max_it_r}) begin
                  inside_r <= 1'b1;
                  state_r  <= S_DONE;
                end else begin
                  q_r   <= r2[46:22];
                  mop_r <= M_Q2;
                end
              end
              M_Q2: begin
                q4_r  <= prod_r[48:22];
                mop_r <= M_Q4;
              end
              M_Q4: begin
                r8_r     <= prod_r[52:22];
                sq_v_r   <= rxy_r[SQW-1:0];
                sq_res_r <= '0;
                sq_bit_r <= SQW'(1) << (SQW - 1);
                state_r  <= S_SQRT;
              end
              M_T: begin
                t_r   <= prod_sh[OPW-1:0];
                mop_r <= M_NX;
              end
              M_NX: begin
                wx_r  <= sat32(PW'(cx_r) + prod_sh);
                mop_r <= M_NY;
              end
              M_NY: begin
                wy_r  <= sat32(PW'(cy_r) + prod_sh);
                mop_r <= M_NZ;
              end
              M_NZ: begin
                wz_r  <= sat32(PW'(cz_r) + prod_sh);
                mop_r <= M_XX;
              end
              default: mop_r <= M_XX;
            endcase
          end
        end
        S_SQRT: begin
          // one result bit per cycle
          if (sq_bit_r == '0) begin
            rho_r   <= sq_res_r[23:0];
            cop_r   <= C_TH;
            cbusy_r <= 1'b0;
            state_r <= S_CORD;
          end else begin
            if (sq_v_r >= sq_try) begin
              sq_v_r   <= sq_v_r - sq_try;
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
          end
        end
        S_CORD: begin
          if (creq.start) begin
            cbusy_r <= 1'b1;
          end else if (c_done) begin
            cbusy_r <= 1'b0;
            case (cop_r)
              C_TH: th_r <= c_ang_out;
              C_PH: ph_r <= c_ang_out;
              C_ST: begin
                st_r <= c_y[OPW-1:0];
                ct_r <= c_x[OPW-1:0];
              end
              C_SP: begin
                sp_r <= c_y[OPW-1:0];
                cp_r <= c_x[OPW-1:0];
              end
              default: th_r <= c_ang_out;
            endcase
            if (cop_r == C_SP) begin
              mop_r   <= M_T;
              mph_r   <= 1'b0;
              state_r <= S_MUL;
            end else begin
              cop_r <= cop_r + 2'd1;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            in_run_r <= inside_r;
            if (emit) begin
              pcnt_r <= pcnt_r + 22'd1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_it_r <= MAXIT_RST;
    end else if (cfg_valid) begin
      max_it_r <= cfg_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {5'b0, kk_r, jj_r, ii_r,
                     emit ? pcnt_r[PIDX_W-1:0] : {PIDX_W{1'b0}},
                     emit, steps_r, inside_r};
    end
  end

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/mvst_cordic.sv =====
// mvst_cordic: iterative 24-step cordic, vectoring (atan2) or rotation (sin/cos)
// one micro-rotation per cycle, binary angles with a full turn of 2^32
// depends on mvst_pkg
module mvst_cordic (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mvst_pkg::cord_req_t            req,
  input  logic signed [mvst_pkg::CW-1:0] a_in,
  input  logic signed [mvst_pkg::CW-1:0] b_in,
  input  logic [31:0]                    ang_in,
  output logic                           done,
  output logic [31:0]                    ang_out,
  output logic signed [mvst_pkg::CW-1:0] x_out,
  output logic signed [mvst_pkg::CW-1:0] y_out
);
  import mvst_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic                 vec_r;
  logic                 neg_r;
  logic [4:0]           s_r;
  logic signed [CW-1:0] x_r;
  logic signed [CW-1:0] y_r;
  logic signed [ZW-1:0] z_r;

  logic                 rot_neg;
  logic [31:0]          rot_ang;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] tab;
  logic                 plus;
  logic [31:0]          ang_q;

  // rotation argument folded into the right half plane
  always_comb begin
    ang_q   = ang_in + QUARTER_TURN;
    rot_neg = ang_q[31];
    rot_ang = rot_neg ? (ang_in ^ HALF_TURN) : ang_in;
  end

  // one micro-rotation
  always_comb begin
    xs   = x_r >>> s_r;
    ys   = y_r >>> s_r;
    tab  = $signed({{(ZW-32){1'b0}}, ATAN_TAB[s_r]});
    plus = vec_r ? !y_r[CW-1] : z_r[ZW-1];
  end

  // iteration control and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      s_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        s_r    <= '0;
        vec_r  <= req.vec_mode;
        if (req.vec_mode) begin
          neg_r <= 1'b0;
          if (a_in[CW-1]) begin
            x_r <= -a_in;
            y_r <= -b_in;
            z_r <= $signed({{(ZW-32){1'b0}}, HALF_TURN});
          end else begin
            x_r <= a_in;
            y_r <= b_in;
            z_r <= '0;
          end
        end else begin
          neg_r <= rot_neg;
          x_r   <= CORDIC_K;
          y_r   <= '0;
          z_r   <= $signed({{(ZW-32){rot_ang[31]}}, rot_ang});
        end
      end else if (busy_r) begin
        if (plus) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + tab;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - tab;
        end
        if (s_r == 5'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          s_r <= s_r + 5'd1;
        end
      end
    end
  end

  assign done    = done_r;
  assign ang_out = z_r[31:0];
  assign x_out   = neg_r ? -x_r : x_r;
  assign y_out   = neg_r ? -y_r : y_r;

endmodule

// ===== hdl/mvst_check.sv =====
// mvst_check: port-level checks for mandelbulb_voxel_surface_test
// bound to the top level below; needs no package
module mvst_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one voxel at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a voxel is in flight");

  // a surface point is only marked on an inside voxel
  a_emit_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[8] || out_tdata[0]))
    else $error("point emitted on an escaped voxel");

  // at least one step and no point index without a point
  a_steps_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:1] != 7'd0) && (out_tdata[8] || out_tdata[29:9] == 21'd0))
    else $error("bad step count or stray point index");

endmodule

bind mandelbulb_voxel_surface_test mvst_check u_mvst_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
